// ===== hw/rtl/nalsplit_pkg.sv =====
package nalsplit_pkg;

  localparam int unsigned MaxRes    = 5;
  localparam int unsigned MaxPushes = 4;
  localparam int unsigned CntW      = 3;

  localparam logic [7:0] ByteZero  = 8'h00;
  localparam logic [7:0] ByteOne   = 8'h01;
  localparam logic [4:0] TypeMask  = 5'h1f;
  localparam logic [4:0] TypeSps   = 5'd7;
  localparam logic [4:0] TypePps   = 5'd8;

  typedef enum logic [1:0] {
    KindOther = 2'd0,
    KindSps   = 2'd1,
    KindPps   = 2'd2
  } param_kind_e;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [4:0] nal_type;
    logic       nal_first;
    logic       nal_last;
    logic [1:0] param_kind;
    logic       packet_end;
    logic       packet_status;
    logic       param_set_seen;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic                   closes;
    logic [CntW-1:0]        count;
    result_t [MaxRes-1:0]   res;
  } batch_t;

endpackage

// ===== hw/rtl/nalsplit_if.sv =====
interface nalsplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface nalsplit_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [4:0] nal_type;
  logic       nal_first;
  logic       nal_last;
  logic [1:0] param_kind;
  logic       packet_end;
  logic       packet_status;
  logic       param_set_seen;
  logic       last_result;

  modport source (
    output valid, input ready,
    output payload_valid, output payload_byte, output nal_type, output nal_first,
    output nal_last, output param_kind, output packet_end, output packet_status,
    output param_set_seen, output last_result
  );
  modport sink (
    input valid, output ready,
    input payload_valid, input payload_byte, input nal_type, input nal_first,
    input nal_last, input param_kind, input packet_end, input packet_status,
    input param_set_seen, input last_result
  );
endinterface

// ===== hw/rtl/nalsplit_step.sv =====
module nalsplit_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_eop_i,
  output logic                  in_ready_o,
  input  logic                  free_i,
  output logic                  load_o,
  output nalsplit_pkg::batch_t  batch_o
);
  import nalsplit_pkg::*;

  logic       inq_valid_q;
  logic [7:0] inq_byte_q;
  logic       inq_eop_q;

  logic [1:0] pz_q, pz_d;
  logic       hv_q, hv_d;
  logic [7:0] hb_q, hb_d;
  logic       hf_q, hf_d;
  logic [4:0] ct_q, ct_d;
  logic       innal_q, innal_d;
  logic       ef_q, ef_d;
  logic       ps_q, ps_d;

  logic            is_zero;
  logic            is_start;
  logic [CntW-1:0] np;
  logic [CntW-1:0] cnt;
  logic [7:0]      push_byte;
  batch_t          batch;

  function automatic result_t make_res(input logic valid, input logic [7:0] data,
                                       input logic first, input logic last,
                                       input logic [4:0] ntype);
    result_t r;
    r = '0;
    if (valid) begin
      r.payload_valid = 1'b1;
      r.payload_byte  = data;
      r.nal_type      = ntype & TypeMask;
      r.nal_first     = first;
      r.nal_last      = last;
      if (ntype == TypeSps) begin
        r.param_kind = KindSps;
      end else if (ntype == TypePps) begin
        r.param_kind = KindPps;
      end else begin
        r.param_kind = KindOther;
      end
    end
    return r;
  endfunction

  assign load_o     = inq_valid_q && free_i;
  assign in_ready_o = !inq_valid_q || free_i;
  assign batch_o    = batch;

  always_comb begin
    pz_d    = pz_q;
    hv_d    = hv_q;
    hb_d    = hb_q;
    hf_d    = hf_q;
    ct_d    = ct_q;
    innal_d = innal_q;
    ef_d    = ef_q;
    ps_d    = ps_q;
    batch   = '0;
    cnt     = '0;
    np      = '0;

    is_zero  = inq_byte_q == ByteZero;
    is_start = (inq_byte_q == ByteOne) && (pz_q >= 2'd2);

    if (is_zero) begin
      if (pz_q != 2'd3) begin
        pz_d = pz_q + 2'd1;
      end else begin
        np = CntW'(1);
      end
    end else if (is_start) begin
      if (hv_d) begin
        batch.res[cnt] = make_res(1'b1, hb_d, hf_d, 1'b1, ct_d);
        cnt = cnt + CntW'(1);
      end
      hv_d    = 1'b0;
      innal_d = 1'b1;
      ef_d    = 1'b1;
      pz_d    = '0;
    end else begin
      np   = CntW'(pz_q) + CntW'(1);
      pz_d = '0;
    end

    if (inq_eop_q) begin
      np   = np + CntW'(pz_d);
      pz_d = '0;
    end

    for (int k = 0; k < MaxPushes; k++) begin
      push_byte = (!is_zero && !is_start && (CntW'(k) == np - CntW'(1))) ? inq_byte_q
                                                                          : ByteZero;
      if ((CntW'(k) < np) && innal_d) begin
        if (hv_d) begin
          batch.res[cnt] = make_res(1'b1, hb_d, hf_d, 1'b0, ct_d);
          cnt = cnt + CntW'(1);
        end
        hv_d = 1'b1;
        hb_d = push_byte;
        hf_d = ef_d;
        if (ef_d) begin
          ct_d = push_byte[4:0] & TypeMask;
          ef_d = 1'b0;
          if ((ct_d == TypeSps) || (ct_d == TypePps)) begin
            ps_d = 1'b1;
          end
        end
      end
    end

    if (inq_eop_q) begin
      if (hv_d) begin
        batch.res[cnt] = make_res(1'b1, hb_d, hf_d, 1'b1, ct_d);
        cnt = cnt + CntW'(1);
      end
      if (cnt == '0) begin
        batch.res[0] = '0;
        cnt = CntW'(1);
      end
      batch.res[cnt - CntW'(1)].packet_end     = 1'b1;
      batch.res[cnt - CntW'(1)].packet_status  = !innal_d;
      batch.res[cnt - CntW'(1)].param_set_seen = ps_d;
      pz_d    = '0;
      hv_d    = 1'b0;
      hb_d    = '0;
      hf_d    = 1'b0;
      ct_d    = '0;
      innal_d = 1'b0;
      ef_d    = 1'b0;
      ps_d    = 1'b0;
    end

    if (cnt != '0) begin
      batch.res[cnt - CntW'(1)].last_result = 1'b1;
    end
    batch.count  = cnt;
    batch.closes = inq_eop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      pz_q        <= '0;
      hv_q        <= 1'b0;
      hf_q        <= 1'b0;
      ct_q        <= '0;
      innal_q     <= 1'b0;
      ef_q        <= 1'b0;
      ps_q        <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        inq_valid_q <= 1'b1;
      end else if (load_o) begin
        inq_valid_q <= 1'b0;
      end
      if (load_o) begin
        pz_q    <= pz_d;
        hv_q    <= hv_d;
        hf_q    <= hf_d;
        ct_q    <= ct_d;
        innal_q <= innal_d;
        ef_q    <= ef_d;
        ps_q    <= ps_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_byte_q <= in_byte_i;
      inq_eop_q  <= in_eop_i;
    end
    if (load_o) begin
      hb_q <= hb_d;
    end
  end

endmodule

// ===== hw/rtl/nalsplit_outbuf.sv =====
module nalsplit_outbuf (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  nalsplit_pkg::batch_t                batch_i,
  output logic                                free_o,
  output logic [nalsplit_pkg::CntW-1:0]       level_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output nalsplit_pkg::result_t               out_res_o
);
  import nalsplit_pkg::*;

  result_t [MaxRes-1:0] buf_q;
  logic [CntW-1:0]      cnt_q;
  logic                 take;

  assign out_valid_o = cnt_q != '0;
  assign take        = out_valid_o && out_ready_i;
  assign free_o      = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);
  assign out_res_o   = buf_q[0];
  assign level_o     = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.count;
    end else if (take) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= batch_i.res;
    end else if (take) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        buf_q[i] <= buf_q[i + 1];
      end
      buf_q[MaxRes-1] <= '0;
    end
  end

endmodule

// ===== hw/rtl/annexb_nal_splitter_top.sv =====
// Channel  Direction  Role    Carries
// in_i     input      sink    data_byte, end_of_packet
// out_o    output     source  one result per request, payload byte and packet marks
//
// A byte passes an input register and then a result buffer before its results appear;
// bytes are taken one per cycle while each causes one result and the output is ready.
// A byte with more than one result holds the output until all are taken, one per
// cycle while the output is ready; the input register keeps the next byte meanwhile.
// Reset clears the parser state and both stages at once; there is no clearing pass.
// A stall on the output stops draining and, once the input register is full, the input.
module annexb_nal_splitter_top (
  input logic            clk_i,
  input logic            rst_ni,
  nalsplit_in_if.sink    in_i,
  nalsplit_out_if.source out_o
);
  import nalsplit_pkg::*;

  logic            free;
  logic            load;
  batch_t          batch;
  logic [CntW-1:0] level;
  result_t         res;

  nalsplit_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.data_byte),
    .in_eop_i   (in_i.end_of_packet),
    .in_ready_o (in_i.ready),
    .free_i     (free),
    .load_o     (load),
    .batch_o    (batch)
  );

  nalsplit_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .batch_i     (batch),
    .free_o      (free),
    .level_o     (level),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.payload_valid  = res.payload_valid;
  assign out_o.payload_byte   = res.payload_byte;
  assign out_o.nal_type       = res.nal_type;
  assign out_o.nal_first      = res.nal_first;
  assign out_o.nal_last       = res.nal_last;
  assign out_o.param_kind     = res.param_kind;
  assign out_o.packet_end     = res.packet_end;
  assign out_o.packet_status  = res.packet_status;
  assign out_o.param_set_seen = res.param_set_seen;
  assign out_o.last_result    = res.last_result;

  a_eop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && batch.closes |-> batch.count != '0)
    else $error("Packet end produced no result.");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= CntW'(MaxRes))
    else $error("Result buffer level out of range.");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.packet_end |-> out_o.last_result)
    else $error("Packet end not on the final result of its byte.");

  a_empty_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.payload_valid |-> out_o.packet_end)
    else $error("Result without payload outside packet end.");

endmodule

// ===== tb/nalsplit_checker.sv =====
module nalsplit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  nalsplit_in_if      in_i,
  nalsplit_out_if     out_i,
  output int unsigned fail_cnt_o,
  output int unsigned due_cnt_o,
  output int unsigned checked_cnt_o,
  output int unsigned unit_cnt_o
);
  import nalsplit_pkg::*;

  logic [1:0] zero_run;
  logic       held_vld;
  logic [7:0] held_byt;
  logic       held_fst;
  logic [4:0] unit_type;
  logic       in_unit;
  logic       want_first;
  logic       pset_found;

  result_t     step_res [MaxRes];
  int unsigned step_cnt;
  result_t     nal_bytes_due [$];

  function void clear_parser();
    zero_run   = '0;
    held_vld   = 1'b0;
    held_byt   = '0;
    held_fst   = 1'b0;
    unit_type  = '0;
    in_unit    = 1'b0;
    want_first = 1'b0;
    pset_found = 1'b0;
  endfunction

  function void emit_result(input logic vld, input logic [7:0] b, input logic fst,
                            input logic lst);
    result_t r;
    r = '0;
    if (vld) begin
      r.payload_valid = 1'b1;
      r.payload_byte  = b;
      r.nal_type      = unit_type;
      r.nal_first     = fst;
      r.nal_last      = lst;
      if (unit_type == TypeSps) begin
        r.param_kind = KindSps;
      end else if (unit_type == TypePps) begin
        r.param_kind = KindPps;
      end else begin
        r.param_kind = KindOther;
      end
    end
    if (step_cnt < MaxRes) begin
      step_res[step_cnt] = r;
      step_cnt++;
    end
  endfunction

  function void flush_held(input logic lst);
    if (held_vld) begin
      emit_result(1'b1, held_byt, held_fst, lst);
      held_vld = 1'b0;
    end
  endfunction

  function void take_payload(input logic [7:0] b);
    if (in_unit) begin
      flush_held(1'b0);
      held_vld = 1'b1;
      held_byt = b;
      held_fst = want_first;
      if (want_first) begin
        unit_type  = b[4:0] & TypeMask;
        want_first = 1'b0;
        if (unit_type == TypeSps || unit_type == TypePps) begin
          pset_found = 1'b1;
        end
      end
    end
  endfunction

  function void parse_byte(input logic [7:0] b, input logic eop);
    int unsigned n;
    step_cnt = 0;
    if (b == ByteZero) begin
      if (zero_run < 2'd3) begin
        zero_run = zero_run + 2'd1;
      end else begin
        take_payload(ByteZero);
      end
    end else if (b == ByteOne && zero_run >= 2'd2) begin
      flush_held(1'b1);
      in_unit    = 1'b1;
      want_first = 1'b1;
      zero_run   = '0;
    end else begin
      n = 32'(zero_run);
      for (int unsigned i = 0; i < n; i++) take_payload(ByteZero);
      zero_run = '0;
      take_payload(b);
    end
    if (eop) begin
      n = 32'(zero_run);
      for (int unsigned i = 0; i < n; i++) take_payload(ByteZero);
      zero_run = '0;
      flush_held(1'b1);
      if (step_cnt == 0) begin
        emit_result(1'b0, ByteZero, 1'b0, 1'b0);
      end
      step_res[step_cnt-1].packet_end     = 1'b1;
      step_res[step_cnt-1].packet_status  = !in_unit;
      step_res[step_cnt-1].param_set_seen = pset_found;
      clear_parser();
    end
    if (step_cnt != 0) begin
      step_res[step_cnt-1].last_result = 1'b1;
    end
    for (int unsigned i = 0; i < step_cnt; i++) nal_bytes_due.push_back(step_res[i]);
  endfunction

  function void check_field(input string name, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt_o++;
    end
  endfunction

  function void compare_result();
    result_t want;
    if (nal_bytes_due.size() == 0) begin
      $error("result_valid: a result arrived with none expected");
      fail_cnt_o++;
    end else begin
      want = nal_bytes_due.pop_front();
      check_field("payload_valid", 32'(want.payload_valid), 32'(out_i.payload_valid));
      check_field("payload_byte", 32'(want.payload_byte), 32'(out_i.payload_byte));
      check_field("nal_type", 32'(want.nal_type), 32'(out_i.nal_type));
      check_field("nal_first", 32'(want.nal_first), 32'(out_i.nal_first));
      check_field("nal_last", 32'(want.nal_last), 32'(out_i.nal_last));
      check_field("param_kind", 32'(want.param_kind), 32'(out_i.param_kind));
      check_field("packet_end", 32'(want.packet_end), 32'(out_i.packet_end));
      check_field("packet_status", 32'(want.packet_status), 32'(out_i.packet_status));
      check_field("param_set_seen", 32'(want.param_set_seen),
                  32'(out_i.param_set_seen));
      check_field("last_result", 32'(want.last_result), 32'(out_i.last_result));
      checked_cnt_o++;
      if (want.nal_first) begin
        unit_cnt_o++;
      end
    end
  endfunction

  initial begin
    fail_cnt_o    = 0;
    due_cnt_o     = 0;
    checked_cnt_o = 0;
    unit_cnt_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      nal_bytes_due.delete();
      due_cnt_o = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        parse_byte(in_i.data_byte, in_i.end_of_packet);
      end
      if (out_i.valid && out_i.ready) begin
        compare_result();
      end
      due_cnt_o = nal_bytes_due.size();
    end
  end

  // Anything left in the queue at the end is picked up by the top through due_cnt_o.

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import nalsplit_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 12;

  logic clk_i;
  logic rst_ni;

  int unsigned src_idle;
  int unsigned snk_idle;
  int unsigned cycle_cnt;
  int unsigned bytes_sent;
  int unsigned packets_sent;
  int unsigned fail_cnt;
  int unsigned due_cnt;
  int unsigned checked_cnt;
  int unsigned unit_cnt;

  logic [7:0] pkt_q [$];

  nalsplit_in_if  in_w ();
  nalsplit_out_if out_w ();

  annexb_nal_splitter_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  nalsplit_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_w),
    .out_i         (out_w),
    .fail_cnt_o    (fail_cnt),
    .due_cnt_o     (due_cnt),
    .checked_cnt_o (checked_cnt),
    .unit_cnt_o    (unit_cnt)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_w.ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("annexb_nal_splitter_top regression: fail");
      $finish;
    end
  end

  function logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(9) < 3) begin
      b = ByteZero;
    end else if ($urandom_range(9) == 0) begin
      b = ByteOne;
    end
    return b;
  endfunction

  function void add_unit();
    int unsigned zeros;
    int unsigned len;
    logic [7:0]  hdr;
    zeros = ($urandom_range(2) == 0) ? 3 : 2;
    if ($urandom_range(9) == 0) begin
      zeros += $urandom_range(1, 3);
    end
    repeat (zeros) pkt_q.push_back(ByteZero);
    pkt_q.push_back(ByteOne);
    len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
    if (len != 0) begin
      hdr = 8'($urandom);
      case ($urandom_range(3))
        0: hdr[4:0] = TypeSps;
        1: hdr[4:0] = TypePps;
        default: ;
      endcase
      pkt_q.push_back(hdr);
      for (int unsigned i = 1; i < len; i++) pkt_q.push_back(body_byte());
    end
  endfunction

  function void build_packet();
    pkt_q.delete();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 8)) pkt_q.push_back(body_byte());
    end else begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 3)) pkt_q.push_back(body_byte());
      end
      repeat ($urandom_range(1, 3)) add_unit();
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 4)) pkt_q.push_back(ByteZero);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eop);
    if ($urandom_range(99) < src_idle) begin
      in_w.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    in_w.valid         <= 1'b1;
    in_w.data_byte     <= b;
    in_w.end_of_packet <= eop;
    do @(posedge clk_i); while (!in_w.ready);
    bytes_sent++;
  endtask

  task automatic send_packet();
    for (int unsigned i = 0; i < pkt_q.size(); i++) begin
      send_byte(pkt_q[i], i == pkt_q.size() - 1);
    end
    packets_sent++;
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_w.valid         = 1'b0;
    in_w.data_byte     = '0;
    in_w.end_of_packet = 1'b0;
    out_w.ready        = 1'b0;
    cycle_cnt          = 0;
    bytes_sent         = 0;
    packets_sent       = 0;
    src_idle           = 37;
    snk_idle           = 54;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No start code at all, with a zero still held back at packet end.
    pkt_q = '{8'hff, 8'h00};
    send_packet();
    // A sequence parameter set, a run of four zeros whose first trails the set as payload
    // and whose rest opens a four-byte start code, and a two-byte picture parameter set that closes the packet.
    pkt_q = '{8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
              8'h68, 8'h80};
    send_packet();
    // An empty unit between two start codes, then trailing zeros flushed as payload.
    pkt_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'he5, 8'h41,
              8'h00, 8'h00};
    send_packet();
    // A start code directly followed by packet end.
    pkt_q = '{8'h00, 8'h00, 8'h01};
    send_packet();

    while (bytes_sent < 225) begin
      if (bytes_sent < 100) begin
        src_idle = 37;
        snk_idle = 54;
      end else if (bytes_sent < 170) begin
        src_idle = 54;
        snk_idle = 37;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      build_packet();
      send_packet();
    end

    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (due_cnt != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d packets under three idling patterns.",
             bytes_sent, packets_sent);
    $display("Checked %0d results covering %0d NAL units.", checked_cnt, unit_cnt);
    if (fail_cnt == 0 && due_cnt == 0) begin
      $display("annexb_nal_splitter_top regression: pass");
    end else begin
      $display("annexb_nal_splitter_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/nalsplit_pkg.sv
hw/rtl/nalsplit_if.sv
hw/rtl/nalsplit_step.sv
hw/rtl/nalsplit_outbuf.sv
hw/rtl/annexb_nal_splitter_top.sv
tb/nalsplit_checker.sv
tb/tb_top.sv
